// ===== design/rpaf_pkg.sv =====
// ----------------------------------------------------------------------------
// Radio packet accept filter package
// Shared codes, constants and the verdict record that passes from the byte
// front end through the queue to the verdict stage.
// ----------------------------------------------------------------------------
package rpaf_pkg;

   // Default limit on the payload length.
   localparam int MAX_PACKET_BYTES_DEFAULT = 64;

   // Verdict queue geometry (depth is a power of two so pointers wrap).
   localparam int QUEUE_DEPTH      = 2;
   localparam int QUEUE_PTR_BITS   = 1;
   localparam int QUEUE_COUNT_BITS = 2;

   // Filter modes.
   typedef enum logic [1:0] {
      MODE_VALID     = 2'd0,
      MODE_TRIGGERED = 2'd1,
      MODE_PASS      = 2'd2,
      MODE_TAG       = 2'd3
   } filter_mode_type;

   localparam filter_mode_type FILTER_MODE_RESET = MODE_TRIGGERED;

   // Verdict reasons.
   typedef enum logic [2:0] {
      R_OK       = 3'd0,
      R_OVERSIZE = 3'd1,
      R_SHORT    = 3'd2,
      R_MAGIC    = 3'd3,
      R_VERSION  = 3'd4,
      R_CHECKSUM = 3'd5,
      R_TRIGGER  = 3'd6
   } reason_type;

   // Header bytes and their positions.
   localparam logic [7:0] MAGIC_BYTE_0   = 8'h47;
   localparam logic [7:0] MAGIC_BYTE_1   = 8'h4F;
   localparam logic [7:0] VERSION_LOW    = 8'h31;
   localparam logic [7:0] VERSION_HIGH   = 8'h35;
   localparam logic [7:0] POS_MAGIC_0    = 8'd0;
   localparam logic [7:0] POS_MAGIC_1    = 8'd1;
   localparam logic [7:0] POS_VERSION    = 8'd2;
   localparam logic [7:0] POS_TRIGGER    = 8'd15;
   localparam logic [7:0] POS_SATURATE   = 8'd255;

   // Checksum trailer size, key mode minimum length and trigger threshold.
   localparam logic [7:0] CHECKSUM_TAIL  = 8'd6;
   localparam logic [7:0] KEY_MIN_LENGTH = 8'd16;
   localparam logic [3:0] TRIGGER_MIN    = 4'd3;

   // Everything the verdict stage needs about one finished packet.
   typedef struct packed {
      logic [7:0]        length;
      logic signed [8:0] strength;
      logic              truncated;
      logic              magic_good;
      logic              version_good;
      logic [15:0]       running_sum;
      logic [15:0]       stored_checksum;
      logic [3:0]        trigger_nibble;
   } verdict_rec_type;

endpackage

// ===== design/rpaf_front.sv =====
// ----------------------------------------------------------------------------
// Radio packet accept filter: byte front end
// Accepts one payload byte per cycle while req_stall is low, keeps the running sum and captures the
// header, checksum and trigger bytes. On the last byte it pushes a record.
// ----------------------------------------------------------------------------
module rpaf_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [7:0]               req_byte_value,
   input  logic [7:0]               req_packet_length,
   input  logic                     req_last_byte,
   input  logic signed [8:0]        req_signal_strength,
   input  logic                     queue_full,
   output logic                     queue_push,
   output rpaf_pkg::verdict_rec_type queue_rec
);

   logic [7:0]  pos_ff,     pos_in;
   logic [15:0] sum_ff,     sum_in;
   logic [15:0] chk_ff,     chk_in;
   logic        magic_ff,   magic_in;
   logic        version_ff, version_in;
   logic [3:0]  nibble_ff,  nibble_in;

   logic [7:0]  tail;
   logic [8:0]  received;
   logic        accept;

   // The queue must have room before a word is taken.
   assign req_stall  = queue_full;
   assign accept     = req_valid && !req_stall;
   assign queue_push = accept && req_last_byte;

   // Per-byte state update, as seen after this byte.
   always_comb begin
      magic_in   = magic_ff;
      version_in = version_ff;
      nibble_in  = nibble_ff;
      sum_in     = sum_ff;
      chk_in     = chk_ff;
      tail       = req_packet_length - rpaf_pkg::CHECKSUM_TAIL;

      if (pos_ff == rpaf_pkg::POS_MAGIC_0 && req_byte_value != rpaf_pkg::MAGIC_BYTE_0) begin
         magic_in = 1'b0;
      end
      if (pos_ff == rpaf_pkg::POS_MAGIC_1 && req_byte_value != rpaf_pkg::MAGIC_BYTE_1) begin
         magic_in = 1'b0;
      end
      if (pos_ff == rpaf_pkg::POS_VERSION) begin
         version_in = (req_byte_value >= rpaf_pkg::VERSION_LOW) &&
                      (req_byte_value <= rpaf_pkg::VERSION_HIGH);
      end
      if (pos_ff == rpaf_pkg::POS_TRIGGER) begin
         nibble_in = req_byte_value[3:0];
      end

      // Sum the body and capture the big-endian checksum trailer.
      if (req_packet_length >= rpaf_pkg::CHECKSUM_TAIL) begin
         if (pos_ff < tail) begin
            sum_in = sum_ff + {8'd0, req_byte_value};
         end
         if (pos_ff == tail) begin
            chk_in = {req_byte_value, chk_ff[7:0]};
         end
         if (pos_ff == tail + 8'd1) begin
            chk_in = {chk_ff[15:8], req_byte_value};
         end
      end

      // The byte counter saturates.
      pos_in = (pos_ff == rpaf_pkg::POS_SATURATE) ? pos_ff : pos_ff + 8'd1;

      // Bytes received including this one; a saturated count never reads short.
      received = {1'b0, pos_ff} + 9'd1;

      queue_rec.length          = req_packet_length;
      queue_rec.strength        = req_signal_strength;
      queue_rec.truncated       = received < {1'b0, req_packet_length};
      queue_rec.magic_good      = magic_in;
      queue_rec.version_good    = version_in;
      queue_rec.running_sum     = sum_in;
      queue_rec.stored_checksum = chk_in;
      queue_rec.trigger_nibble  = nibble_in;
   end

   // Packet state; it returns to its start values after each last byte.
   always_ff @(posedge clock) begin
      if (reset || (accept && req_last_byte)) begin
         pos_ff     <= 8'd0;
         sum_ff     <= 16'd0;
         chk_ff     <= 16'd0;
         magic_ff   <= 1'b1;
         version_ff <= 1'b0;
         nibble_ff  <= 4'd0;
      end else if (accept) begin
         pos_ff     <= pos_in;
         sum_ff     <= sum_in;
         chk_ff     <= chk_in;
         magic_ff   <= magic_in;
         version_ff <= version_in;
         nibble_ff  <= nibble_in;
      end
   end

endmodule

// ===== design/rpaf_queue.sv =====
// ----------------------------------------------------------------------------
// Radio packet accept filter: record queue
// A short first-in first-out queue of packet records between the byte front
// end and the verdict stage.
// ----------------------------------------------------------------------------
module rpaf_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  rpaf_pkg::verdict_rec_type push_rec,
   output logic                      full,
   input  logic                      pop,
   output logic                      not_empty,
   output rpaf_pkg::verdict_rec_type pop_rec
);

   localparam int DEPTH = rpaf_pkg::QUEUE_DEPTH;

   rpaf_pkg::verdict_rec_type                 entry_ff [DEPTH];
   logic [rpaf_pkg::QUEUE_PTR_BITS-1:0]   wr_ptr_ff;
   logic [rpaf_pkg::QUEUE_PTR_BITS-1:0]   rd_ptr_ff;
   logic [rpaf_pkg::QUEUE_COUNT_BITS-1:0] count_ff;

   assign full      = count_ff == rpaf_pkg::QUEUE_COUNT_BITS'(DEPTH);
   assign not_empty = count_ff != '0;
   assign pop_rec   = entry_ff[rd_ptr_ff];

   // Storage; a push only happens when there is room.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_rec;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== design/rpaf_back.sv =====
// ----------------------------------------------------------------------------
// Radio packet accept filter: verdict stage
// Takes a packet record from the queue, works out the first failing check
// and holds the verdict in the output register until it is taken.
// ----------------------------------------------------------------------------
module rpaf_back #(
   parameter int MAX_PACKET_BYTES = rpaf_pkg::MAX_PACKET_BYTES_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  rpaf_pkg::filter_mode_type filter_mode,
   input  logic                      queue_not_empty,
   input  rpaf_pkg::verdict_rec_type queue_rec,
   output logic                      queue_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_accepted,
   output logic [2:0]                rsp_reject_reason,
   output logic [7:0]                rsp_verdict_length,
   output logic signed [8:0]         rsp_verdict_strength
);

   localparam logic [7:0] MaxLength = 8'(MAX_PACKET_BYTES);

   logic                 valid_ff;
   rpaf_pkg::reason_type reason_ff,   reason_in;
   logic [7:0]           length_ff;
   logic signed [8:0]    strength_ff;
   logic                 key_mode;

   assign key_mode  = filter_mode == rpaf_pkg::MODE_TRIGGERED;
   assign queue_pop = queue_not_empty && (!valid_ff || !rsp_stall);

   // Checks in priority order; the first failure names the reason.
   always_comb begin
      if (queue_rec.length > MaxLength) begin
         reason_in = rpaf_pkg::R_OVERSIZE;
      end else if (filter_mode == rpaf_pkg::MODE_PASS) begin
         reason_in = rpaf_pkg::R_OK;
      end else if (queue_rec.length < rpaf_pkg::CHECKSUM_TAIL || queue_rec.truncated ||
                   (key_mode && queue_rec.length < rpaf_pkg::KEY_MIN_LENGTH)) begin
         reason_in = rpaf_pkg::R_SHORT;
      end else if (!queue_rec.magic_good) begin
         reason_in = rpaf_pkg::R_MAGIC;
      end else if (!queue_rec.version_good) begin
         reason_in = rpaf_pkg::R_VERSION;
      end else if (queue_rec.running_sum != queue_rec.stored_checksum) begin
         reason_in = rpaf_pkg::R_CHECKSUM;
      end else if (key_mode && queue_rec.trigger_nibble < rpaf_pkg::TRIGGER_MIN) begin
         reason_in = rpaf_pkg::R_TRIGGER;
      end else begin
         reason_in = rpaf_pkg::R_OK;
      end
   end

   // Output register valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (queue_pop) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   // Output register payload.
   always_ff @(posedge clock) begin
      if (queue_pop) begin
         reason_ff   <= reason_in;
         length_ff   <= queue_rec.length;
         strength_ff <= queue_rec.strength;
      end
   end

   assign rsp_valid            = valid_ff;
   assign rsp_accepted         = reason_ff == rpaf_pkg::R_OK;
   assign rsp_reject_reason    = reason_ff;
   assign rsp_verdict_length   = length_ff;
   assign rsp_verdict_strength = strength_ff;

endmodule

// ===== design/radio_packet_accept_filter.sv =====
// ----------------------------------------------------------------------------
// Radio packet accept filter
// Judges received radio payloads byte by byte and gives one verdict per
// packet on its last byte.
// ----------------------------------------------------------------------------
// Payload bytes are taken one word per clock while req_stall is low, with no
// gaps needed: the byte front end updates the running sum and header
// captures as each byte is accepted, so a new packet may start right after
// a last byte. Each last byte pushes a record into a two-entry queue; the
// verdict stage checks it once the output register is free and registers
// the verdict there, where it shows on the result ports. It is held in the
// output register while rsp_stall is high. req_stall rises only when the
// queue is full, which takes a stalled result side. The mode register is
// always ready and should be written only while no packet is in flight.
// ----------------------------------------------------------------------------
module radio_packet_accept_filter #(
   parameter int MAX_PACKET_BYTES = rpaf_pkg::MAX_PACKET_BYTES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_byte_value,
   input  logic [7:0]        req_packet_length,
   input  logic              req_last_byte,
   input  logic signed [8:0] req_signal_strength,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_accepted,
   output logic [2:0]        rsp_reject_reason,
   output logic [7:0]        rsp_verdict_length,
   output logic signed [8:0] rsp_verdict_strength,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_data
);

   rpaf_pkg::filter_mode_type filter_mode_ff;
   rpaf_pkg::verdict_rec_type push_rec;
   rpaf_pkg::verdict_rec_type pop_rec;
   logic                      queue_push;
   logic                      queue_pop;
   logic                      queue_full;
   logic                      queue_not_empty;

   // Mode register.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_mode_ff <= rpaf_pkg::FILTER_MODE_RESET;
      end else if (csr_valid && csr_ready) begin
         filter_mode_ff <= rpaf_pkg::filter_mode_type'(csr_data);
      end
   end

   rpaf_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_byte_value      (req_byte_value),
      .req_packet_length   (req_packet_length),
      .req_last_byte       (req_last_byte),
      .req_signal_strength (req_signal_strength),
      .queue_full          (queue_full),
      .queue_push          (queue_push),
      .queue_rec           (push_rec)
   );

   rpaf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_rec  (push_rec),
      .full      (queue_full),
      .pop       (queue_pop),
      .not_empty (queue_not_empty),
      .pop_rec   (pop_rec)
   );

   rpaf_back #(
      .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .filter_mode          (filter_mode_ff),
      .queue_not_empty      (queue_not_empty),
      .queue_rec            (pop_rec),
      .queue_pop            (queue_pop),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_accepted         (rsp_accepted),
      .rsp_reject_reason    (rsp_reject_reason),
      .rsp_verdict_length   (rsp_verdict_length),
      .rsp_verdict_strength (rsp_verdict_strength)
   );

endmodule

// ===== design/rpaf_checker.sv =====
// ----------------------------------------------------------------------------
// Radio packet accept filter checker
// Port-level assertions on the verdict channel, bound to the top level.
// ----------------------------------------------------------------------------
module rpaf_checker #(
   parameter int MAX_PACKET_BYTES = rpaf_pkg::MAX_PACKET_BYTES_DEFAULT
) (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic              rsp_accepted,
   input logic [2:0]        rsp_reject_reason,
   input logic [7:0]        rsp_verdict_length,
   input logic signed [8:0] rsp_verdict_strength
);

   localparam logic [7:0] MaxLength = 8'(MAX_PACKET_BYTES);

   // A stalled verdict stays up with the same contents.
   held_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_reject_reason) &&
      $stable(rsp_verdict_length) && $stable(rsp_verdict_strength))
      else $error("stalled verdict changed");

   // The accept flag agrees with the reason code.
   accept_matches_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_accepted == (rsp_reject_reason == rpaf_pkg::R_OK))
      else $error("accept flag disagrees with reason");

   // An overlong packet is always rejected as oversize, and only it is.
   oversize_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_verdict_length > MaxLength) ==
                    (rsp_reject_reason == rpaf_pkg::R_OVERSIZE))
      else $error("oversize verdict mismatch");

   // Reason codes stay within the defined set.
   reason_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_reject_reason <= rpaf_pkg::R_TRIGGER)
      else $error("undefined reason code");

endmodule

bind radio_packet_accept_filter rpaf_checker #(
   .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
) u_rpaf_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_accepted         (rsp_accepted),
   .rsp_reject_reason    (rsp_reject_reason),
   .rsp_verdict_length   (rsp_verdict_length),
   .rsp_verdict_strength (rsp_verdict_strength)
);
